[hw/rtl/bpa_pkg.sv]
package bpa_pkg;

  localparam int FRAME_COUNT = 512;
  localparam int TOP_ORDER   = 9;
  localparam int FRAME_W     = 9;
  localparam int CNT_W       = 10;
  localparam int ORD_W       = 4;
  localparam int CAP_RESET   = 250;

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [ORD_W-1:0]   order_t;

  localparam logic [1:0] FN_ALLOC  = 2'd0;
  localparam logic [1:0] FN_FREE   = 2'd1;
  localparam logic [1:0] FN_ACCESS = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_NOBLK  = 2'd1;
  localparam logic [1:0] ST_FREEPG = 2'd2;

  localparam logic [1:0] MK_NONE   = 2'd0;
  localparam logic [1:0] MK_INACT  = 2'd1;
  localparam logic [1:0] MK_ACT    = 2'd2;

  typedef struct packed {
    logic       free;
    logic       head;
    order_t     order;
    logic [1:0] mark;
  } fword_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_LOAD, OP_ST1, OP_ST2, OP_SCAN_INIT, OP_SCAN, OP_GRANT,
    OP_SPLIT, OP_FILL, OP_RDPG, OP_RM_INIT, OP_RM_RD, OP_RM_NEXT, OP_RM_SRD,
    OP_RM_SWR, OP_RM_END, OP_REL_INIT, OP_REL_RD, OP_REL_M1, OP_REL_M2,
    OP_MARK, OP_PUSH, OP_TAIL_RD, OP_TAIL_TAKE, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       lsel;   // 0 inactive list, 1 active list
    logic       vsel;   // 0 request page, 1 list tail
    logic [1:0] mark;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] func;
    logic       too_big;
    logic       scan_end;
    logic       found;
    logic       split_done;
    logic       fill_last;
    logic       pg_free;
    logic [1:0] pg_mark;
    logic       rm_end;
    logic       rm_last;
    logic       rm_hit;
    logic       rel_end;
    logic       rel_merge;
    logic       i_over;
    logic       a_over;
    logic       out_free;
  } sts_t;

  function automatic order_t ord_of(input count_t cnt);
    order_t o;
    o = '0;
    for (int i = 0; i <= TOP_ORDER; i++) begin
      if ((count_t'(1) << i) < cnt) o = order_t'(i + 1);
    end
    return o;
  endfunction

endpackage

[hw/rtl/bpa_ifs.sv]
interface bpa_req_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              func;
  logic [bpa_pkg::CNT_W-1:0] page_count;
  logic [bpa_pkg::FRAME_W-1:0] page;
  modport source (output valid, func, page_count, page, input ready);
  modport sink   (input valid, func, page_count, page, output ready);
endinterface

interface bpa_rsp_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [bpa_pkg::FRAME_W-1:0] base_page;
  logic [bpa_pkg::ORD_W-1:0]   granted_order;
  logic                    evicted;
  logic [bpa_pkg::FRAME_W-1:0] evicted_page;
  logic                    demoted;
  logic [bpa_pkg::FRAME_W-1:0] demoted_page;
  modport source (output valid, status, base_page, granted_order, evicted, evicted_page,
                  demoted, demoted_page, input ready);
  modport sink   (input valid, status, base_page, granted_order, evicted, evicted_page,
                  demoted, demoted_page, output ready);
endinterface

interface bpa_cfg_if;
  logic                    valid;
  logic                    ready;
  logic [bpa_pkg::CNT_W-1:0] list_capacity;
  modport source (output valid, list_capacity, input ready);
  modport sink   (input valid, list_capacity, output ready);
endinterface

[hw/rtl/bpa_datapath.sv]
module bpa_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bpa_pkg::cmd_t           cmd,
  output bpa_pkg::sts_t           sts,
  input  logic [1:0]              in_func,
  input  bpa_pkg::count_t         in_page_count,
  input  bpa_pkg::frame_t         in_page,
  input  logic                    cfg_valid,
  input  bpa_pkg::count_t         cfg_data,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output bpa_pkg::frame_t         out_base_page,
  output bpa_pkg::order_t         out_granted_order,
  output logic                    out_evicted,
  output bpa_pkg::frame_t         out_evicted_page,
  output logic                    out_demoted,
  output bpa_pkg::frame_t         out_demoted_page
);

  bpa_pkg::fword_t fmem [bpa_pkg::FRAME_COUNT];
  bpa_pkg::frame_t imem [bpa_pkg::FRAME_COUNT];
  bpa_pkg::frame_t amem [bpa_pkg::FRAME_COUNT];

  bpa_pkg::fword_t frd_r;
  bpa_pkg::frame_t ird_r, ard_r;

  bpa_pkg::count_t idx_r;
  bpa_pkg::frame_t sa_r;
  logic            sv_r;
  logic            found_r;
  bpa_pkg::frame_t best_r;
  bpa_pkg::order_t bord_r, m_r, ord_r, lvl_r;
  bpa_pkg::frame_t k_r, pg_r, cur_r, tail_r;
  logic [1:0]      func_r;
  logic            big_r;
  bpa_pkg::count_t j_r;
  logic            rsel_r;
  bpa_pkg::frame_t ihead_r, ahead_r;
  bpa_pkg::count_t icnt_r, acnt_r, cap_r;

  logic [1:0]      st_r;
  bpa_pkg::frame_t base_r, evp_r, dmp_r;
  bpa_pkg::order_t gord_r;
  logic            ev_r, dm_r;

  logic            ov_r;
  logic [1:0]      ost_r;
  bpa_pkg::frame_t obase_r, oevp_r, odmp_r;
  bpa_pkg::order_t ogord_r;
  logic            oev_r, odm_r;

  logic            fwe, fre;
  bpa_pkg::frame_t fwa, fra;
  bpa_pkg::fword_t fwd, init_w;
  logic            lwe, lre, usel;
  bpa_pkg::frame_t lwa, lra, lwd, uhead, vval, lrd, rlrd, buddy, mergeup, mergelo;
  bpa_pkg::count_t ucnt, rcnt;
  bpa_pkg::order_t mdec;

  localparam bpa_pkg::frame_t AlignMask = bpa_pkg::FRAME_W'((1 << bpa_pkg::TOP_ORDER) - 1);

  always_comb begin
    init_w = '{free: 1'b1, head: 1'b0, order: '0, mark: bpa_pkg::MK_NONE};
    if ((idx_r[bpa_pkg::FRAME_W-1:0] & AlignMask) == '0) begin
      init_w.head  = 1'b1;
      init_w.order = bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER);
    end
  end

  assign usel    = (cmd.op == bpa_pkg::OP_RM_RD || cmd.op == bpa_pkg::OP_RM_SRD ||
                    cmd.op == bpa_pkg::OP_RM_SWR || cmd.op == bpa_pkg::OP_RM_END ||
                    cmd.op == bpa_pkg::OP_RM_NEXT) ? rsel_r : cmd.lsel;
  assign uhead   = usel ? ahead_r : ihead_r;
  assign ucnt    = usel ? acnt_r : icnt_r;
  assign lrd     = usel ? ard_r : ird_r;
  assign rcnt    = rsel_r ? acnt_r : icnt_r;
  assign rlrd    = rsel_r ? ard_r : ird_r;
  assign vval    = cmd.vsel ? tail_r : pg_r;
  assign buddy   = cur_r ^ (bpa_pkg::frame_t'(1) << lvl_r);
  assign mergeup = (cur_r > buddy) ? cur_r : buddy;
  assign mergelo = (cur_r > buddy) ? buddy : cur_r;
  assign mdec    = m_r - bpa_pkg::order_t'(1);

  always_comb begin
    fwe = 1'b0; fre = 1'b0; fwa = '0; fra = '0; fwd = '0;
    lwe = 1'b0; lre = 1'b0; lwa = '0; lra = '0; lwd = '0;
    unique case (cmd.op)
      bpa_pkg::OP_CLR: begin
        fwe = 1'b1; fwa = idx_r[bpa_pkg::FRAME_W-1:0]; fwd = init_w;
      end
      bpa_pkg::OP_SCAN: begin
        fre = (idx_r != bpa_pkg::CNT_W'(bpa_pkg::FRAME_COUNT));
        fra = idx_r[bpa_pkg::FRAME_W-1:0];
      end
      bpa_pkg::OP_SPLIT: begin
        fwe = 1'b1;
        fwa = best_r + (bpa_pkg::frame_t'(1) << mdec);
        fwd = '{free: 1'b1, head: 1'b1, order: mdec, mark: bpa_pkg::MK_NONE};
      end
      bpa_pkg::OP_FILL: begin
        fwe = 1'b1; fwa = best_r + k_r; fwd = '0;
      end
      bpa_pkg::OP_RDPG: begin
        fre = 1'b1; fra = pg_r;
      end
      bpa_pkg::OP_REL_INIT: begin
        fwe = 1'b1; fwa = vval;
        fwd = '{free: 1'b1, head: 1'b1, order: '0, mark: bpa_pkg::MK_NONE};
      end
      bpa_pkg::OP_REL_RD: begin
        fre = 1'b1; fra = buddy;
      end
      bpa_pkg::OP_REL_M1: begin
        fwe = 1'b1; fwa = mergeup;
        fwd = '{free: 1'b1, head: 1'b0, order: '0, mark: bpa_pkg::MK_NONE};
      end
      bpa_pkg::OP_REL_M2: begin
        fwe = 1'b1; fwa = mergelo;
        fwd = '{free: 1'b1, head: 1'b1, order: lvl_r + bpa_pkg::order_t'(1),
                mark: bpa_pkg::MK_NONE};
      end
      bpa_pkg::OP_MARK: begin
        fwe = 1'b1; fwa = vval;
        fwd = '{free: 1'b0, head: 1'b0, order: '0, mark: cmd.mark};
      end
      bpa_pkg::OP_RM_RD: begin
        lre = 1'b1; lra = uhead + j_r[bpa_pkg::FRAME_W-1:0];
      end
      bpa_pkg::OP_RM_SRD: begin
        lre = 1'b1; lra = uhead + j_r[bpa_pkg::FRAME_W-1:0] + bpa_pkg::frame_t'(1);
      end
      bpa_pkg::OP_RM_SWR: begin
        lwe = 1'b1; lwa = uhead + j_r[bpa_pkg::FRAME_W-1:0]; lwd = lrd;
      end
      bpa_pkg::OP_PUSH: begin
        lwe = (ucnt < bpa_pkg::CNT_W'(bpa_pkg::FRAME_COUNT));
        lwa = uhead - bpa_pkg::frame_t'(1); lwd = vval;
      end
      bpa_pkg::OP_TAIL_RD: begin
        lre = 1'b1;
        lra = uhead + bpa_pkg::FRAME_W'(ucnt - bpa_pkg::count_t'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fwe) fmem[fwa] <= fwd;
    if (fre) frd_r <= fmem[fra];
    if (lwe && !usel) imem[lwa] <= lwd;
    if (lwe && usel)  amem[lwa] <= lwd;
    if (lre && !usel) ird_r <= imem[lra];
    if (lre && usel)  ard_r <= amem[lra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      sv_r    <= 1'b0;
      ihead_r <= '0;
      ahead_r <= '0;
      icnt_r  <= '0;
      acnt_r  <= '0;
      cap_r   <= bpa_pkg::CNT_W'(bpa_pkg::CAP_RESET);
      ov_r    <= 1'b0;
    end else begin
      if (cfg_valid) cap_r <= cfg_data;
      if (cmd.op == bpa_pkg::OP_OUT) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      unique case (cmd.op)
        bpa_pkg::OP_CLR: idx_r <= idx_r + bpa_pkg::count_t'(1);
        bpa_pkg::OP_LOAD: begin
          func_r <= in_func;
          pg_r   <= in_page;
          ord_r  <= bpa_pkg::ord_of(in_page_count);
          big_r  <= (in_page_count > bpa_pkg::CNT_W'(bpa_pkg::FRAME_COUNT)) ||
                    (bpa_pkg::ord_of(in_page_count) > bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER));
          st_r   <= bpa_pkg::ST_DONE;
          base_r <= '0; gord_r <= '0;
          ev_r   <= 1'b0; evp_r <= '0;
          dm_r   <= 1'b0; dmp_r <= '0;
        end
        bpa_pkg::OP_ST1: st_r <= bpa_pkg::ST_NOBLK;
        bpa_pkg::OP_ST2: st_r <= bpa_pkg::ST_FREEPG;
        bpa_pkg::OP_SCAN_INIT: begin
          idx_r <= '0; sv_r <= 1'b0; found_r <= 1'b0;
        end
        bpa_pkg::OP_SCAN: begin
          if (sv_r && frd_r.head && frd_r.order >= ord_r &&
              (!found_r || frd_r.order < bord_r)) begin
            found_r <= 1'b1;
            best_r  <= sa_r;
            bord_r  <= frd_r.order;
          end
          sv_r <= fre;
          sa_r <= idx_r[bpa_pkg::FRAME_W-1:0];
          if (fre) idx_r <= idx_r + bpa_pkg::count_t'(1);
        end
        bpa_pkg::OP_GRANT: begin
          m_r <= bord_r; k_r <= '0; base_r <= best_r; gord_r <= ord_r;
        end
        bpa_pkg::OP_SPLIT: m_r <= mdec;
        bpa_pkg::OP_FILL:  k_r <= k_r + bpa_pkg::frame_t'(1);
        bpa_pkg::OP_RM_INIT: begin
          j_r <= '0; rsel_r <= cmd.lsel;
        end
        bpa_pkg::OP_RM_NEXT, bpa_pkg::OP_RM_SWR: j_r <= j_r + bpa_pkg::count_t'(1);
        bpa_pkg::OP_RM_END: begin
          if (rsel_r) acnt_r <= acnt_r - bpa_pkg::count_t'(1);
          else        icnt_r <= icnt_r - bpa_pkg::count_t'(1);
        end
        bpa_pkg::OP_REL_INIT: begin
          cur_r <= vval; lvl_r <= '0;
        end
        bpa_pkg::OP_REL_M2: begin
          cur_r <= mergelo; lvl_r <= lvl_r + bpa_pkg::order_t'(1);
        end
        bpa_pkg::OP_PUSH: begin
          if (lwe) begin
            if (usel) begin
              ahead_r <= lwa; acnt_r <= acnt_r + bpa_pkg::count_t'(1);
            end else begin
              ihead_r <= lwa; icnt_r <= icnt_r + bpa_pkg::count_t'(1);
            end
          end
        end
        bpa_pkg::OP_TAIL_TAKE: begin
          tail_r <= lrd;
          if (usel) begin
            acnt_r <= acnt_r - bpa_pkg::count_t'(1);
            dm_r <= 1'b1; dmp_r <= lrd;
          end else begin
            icnt_r <= icnt_r - bpa_pkg::count_t'(1);
            ev_r <= 1'b1; evp_r <= lrd;
          end
        end
        bpa_pkg::OP_OUT: begin
          ost_r <= st_r; obase_r <= base_r; ogord_r <= gord_r;
          oev_r <= ev_r; oevp_r <= evp_r; odm_r <= dm_r; odmp_r <= dmp_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sts.clr_last   = (idx_r[bpa_pkg::FRAME_W-1:0] == bpa_pkg::FRAME_W'(bpa_pkg::FRAME_COUNT - 1));
    sts.func       = func_r;
    sts.too_big    = big_r;
    sts.scan_end   = (idx_r == bpa_pkg::CNT_W'(bpa_pkg::FRAME_COUNT));
    sts.found      = found_r;
    sts.split_done = (m_r == ord_r);
    sts.fill_last  = ({1'b0, k_r} == (bpa_pkg::count_t'(1) << ord_r) - bpa_pkg::count_t'(1));
    sts.pg_free    = frd_r.free;
    sts.pg_mark    = frd_r.mark;
    sts.rm_end     = (j_r == rcnt);
    sts.rm_last    = (j_r + bpa_pkg::count_t'(1) == rcnt);
    sts.rm_hit     = (rlrd == pg_r);
    sts.rel_end    = (lvl_r == bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER));
    sts.rel_merge  = frd_r.head && (frd_r.order == lvl_r);
    sts.i_over     = (icnt_r > cap_r);
    sts.a_over     = (acnt_r > cap_r);
    sts.out_free   = !ov_r || out_ready;
  end

  assign out_valid         = ov_r;
  assign out_status        = ost_r;
  assign out_base_page     = obase_r;
  assign out_granted_order = ogord_r;
  assign out_evicted       = oev_r;
  assign out_evicted_page  = oevp_r;
  assign out_demoted       = odm_r;
  assign out_demoted_page  = odmp_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (icnt_r <= bpa_pkg::CNT_W'(bpa_pkg::FRAME_COUNT)) &&
    (acnt_r <= bpa_pkg::CNT_W'(bpa_pkg::FRAME_COUNT)))
    else $error("list count beyond frame count");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(cmd.op == bpa_pkg::OP_OUT))
    else $error("result raised without load");

  a_split: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == bpa_pkg::OP_SPLIT) |-> (m_r > ord_r))
    else $error("split below requested order");

endmodule

[hw/rtl/bpa_ctrl.sv]
module bpa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bpa_pkg::sts_t sts,
  output bpa_pkg::cmd_t cmd
);

  typedef enum logic [25:0] {
    S_CLR    = 26'd1 << 0,  S_IDLE   = 26'd1 << 1,  S_DISP   = 26'd1 << 2,
    S_SCAN   = 26'd1 << 3,  S_AGR    = 26'd1 << 4,  S_SPLIT  = 26'd1 << 5,
    S_FILL   = 26'd1 << 6,  S_PCHK   = 26'd1 << 7,  S_RM_RD  = 26'd1 << 8,
    S_RM_CMP = 26'd1 << 9,  S_RM_SRD = 26'd1 << 10, S_RM_SWR = 26'd1 << 11,
    S_RELI   = 26'd1 << 12, S_REL_RD = 26'd1 << 13, S_REL_CHK = 26'd1 << 14,
    S_REL_M2 = 26'd1 << 15, S_MARK2  = 26'd1 << 16, S_PUSHA  = 26'd1 << 17,
    S_OVA    = 26'd1 << 18, S_TAILA  = 26'd1 << 19, S_MARKT  = 26'd1 << 20,
    S_PUSHT  = 26'd1 << 21, S_PUSHI  = 26'd1 << 22, S_OVI    = 26'd1 << 23,
    S_TAILI  = 26'd1 << 24, S_FIN    = 26'd1 << 25
  } state_t;

  state_t state_r, state_nxt;
  logic   vsel_r, vsel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      vsel_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vsel_r  <= vsel_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    vsel_nxt  = vsel_r;
    cmd       = '{op: bpa_pkg::OP_NONE, lsel: 1'b0, vsel: 1'b0, mark: bpa_pkg::MK_NONE};
    unique case (state_r)
      S_CLR: begin
        cmd.op = bpa_pkg::OP_CLR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = bpa_pkg::OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        priority if (sts.func == bpa_pkg::FN_ALLOC) begin
          if (sts.too_big) begin
            cmd.op = bpa_pkg::OP_ST1; state_nxt = S_FIN;
          end else begin
            cmd.op = bpa_pkg::OP_SCAN_INIT; state_nxt = S_SCAN;
          end
        end else if (sts.func == bpa_pkg::FN_FREE || sts.func == bpa_pkg::FN_ACCESS) begin
          cmd.op = bpa_pkg::OP_RDPG; state_nxt = S_PCHK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        cmd.op = bpa_pkg::OP_SCAN;
        if (sts.scan_end) state_nxt = S_AGR;
      end
      S_AGR: begin
        if (sts.found) begin
          cmd.op = bpa_pkg::OP_GRANT; state_nxt = S_SPLIT;
        end else begin
          cmd.op = bpa_pkg::OP_ST1; state_nxt = S_FIN;
        end
      end
      S_SPLIT: begin
        if (sts.split_done) state_nxt = S_FILL;
        else cmd.op = bpa_pkg::OP_SPLIT;
      end
      S_FILL: begin
        cmd.op = bpa_pkg::OP_FILL;
        if (sts.fill_last) state_nxt = S_FIN;
      end
      S_PCHK: begin
        priority if (sts.pg_free) begin
          cmd.op = bpa_pkg::OP_ST2; state_nxt = S_FIN;
        end else if (sts.func == bpa_pkg::FN_FREE) begin
          vsel_nxt = 1'b0;
          priority if (sts.pg_mark == bpa_pkg::MK_INACT) begin
            cmd.op = bpa_pkg::OP_RM_INIT; state_nxt = S_RM_RD;
          end else if (sts.pg_mark == bpa_pkg::MK_ACT) begin
            cmd.op = bpa_pkg::OP_RM_INIT; cmd.lsel = 1'b1; state_nxt = S_RM_RD;
          end else begin
            state_nxt = S_RELI;
          end
        end else if (sts.pg_mark == bpa_pkg::MK_NONE) begin
          cmd.op = bpa_pkg::OP_MARK; cmd.mark = bpa_pkg::MK_INACT; state_nxt = S_PUSHI;
        end else if (sts.pg_mark == bpa_pkg::MK_INACT) begin
          cmd.op = bpa_pkg::OP_RM_INIT; state_nxt = S_RM_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RM_RD: begin
        if (sts.rm_end) begin
          state_nxt = (sts.func == bpa_pkg::FN_FREE) ? S_RELI : S_MARK2;
        end else begin
          cmd.op = bpa_pkg::OP_RM_RD; state_nxt = S_RM_CMP;
        end
      end
      S_RM_CMP: begin
        if (sts.rm_hit) state_nxt = S_RM_SRD;
        else begin
          cmd.op = bpa_pkg::OP_RM_NEXT; state_nxt = S_RM_RD;
        end
      end
      S_RM_SRD: begin
        if (sts.rm_last) begin
          cmd.op = bpa_pkg::OP_RM_END;
          state_nxt = (sts.func == bpa_pkg::FN_FREE) ? S_RELI : S_MARK2;
        end else begin
          cmd.op = bpa_pkg::OP_RM_SRD; state_nxt = S_RM_SWR;
        end
      end
      S_RM_SWR: begin
        cmd.op = bpa_pkg::OP_RM_SWR; state_nxt = S_RM_SRD;
      end
      S_RELI: begin
        cmd.op = bpa_pkg::OP_REL_INIT; cmd.vsel = vsel_r; state_nxt = S_REL_RD;
      end
      S_REL_RD: begin
        if (sts.rel_end) state_nxt = S_FIN;
        else begin
          cmd.op = bpa_pkg::OP_REL_RD; state_nxt = S_REL_CHK;
        end
      end
      S_REL_CHK: begin
        if (sts.rel_merge) begin
          cmd.op = bpa_pkg::OP_REL_M1; state_nxt = S_REL_M2;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_REL_M2: begin
        cmd.op = bpa_pkg::OP_REL_M2; state_nxt = S_REL_RD;
      end
      S_MARK2: begin
        cmd.op = bpa_pkg::OP_MARK; cmd.mark = bpa_pkg::MK_ACT; state_nxt = S_PUSHA;
      end
      S_PUSHA: begin
        cmd.op = bpa_pkg::OP_PUSH; cmd.lsel = 1'b1; state_nxt = S_OVA;
      end
      S_OVA: begin
        if (sts.a_over) begin
          cmd.op = bpa_pkg::OP_TAIL_RD; cmd.lsel = 1'b1; state_nxt = S_TAILA;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_TAILA: begin
        cmd.op = bpa_pkg::OP_TAIL_TAKE; cmd.lsel = 1'b1; state_nxt = S_MARKT;
      end
      S_MARKT: begin
        cmd.op = bpa_pkg::OP_MARK; cmd.vsel = 1'b1; cmd.mark = bpa_pkg::MK_INACT;
        state_nxt = S_PUSHT;
      end
      S_PUSHT: begin
        cmd.op = bpa_pkg::OP_PUSH; cmd.vsel = 1'b1; state_nxt = S_FIN;
      end
      S_PUSHI: begin
        cmd.op = bpa_pkg::OP_PUSH; state_nxt = S_OVI;
      end
      S_OVI: begin
        if (sts.i_over) begin
          cmd.op = bpa_pkg::OP_TAIL_RD; state_nxt = S_TAILI;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_TAILI: begin
        cmd.op = bpa_pkg::OP_TAIL_TAKE; vsel_nxt = 1'b1; state_nxt = S_RELI;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.op = bpa_pkg::OP_OUT; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == bpa_pkg::OP_OUT) |-> sts.out_free)
    else $error("result loaded over a pending one");

endmodule

[hw/rtl/buddy_page_allocator_with_two_list_lru_unit.sv]
// Channel   Dir  Handshake      Carries
// in_req    in   valid/ready    func, page_count, page
// out_rsp   out  valid/ready    status, base_page, granted_order, evicted/_page,
//                               demoted/_page
// cfg_wr    in   valid/ready    list_capacity (ready always high)
//
// After reset a pass initialises every frame table entry; no request is taken meanwhile.
// One request at a time through a single-port frame table and two list memories.
// Alloc: a frame-table scan, then one split per split level and one fill per granted page.
// Free/access: per entry searched a read and compare, per entry shifted a read and write.
// A finished result waits in the output register while the next request is taken.
module buddy_page_allocator_with_two_list_lru_unit (
  input  logic   clk,
  input  logic   rst_n,
  bpa_req_if.sink   in_req,
  bpa_rsp_if.source out_rsp,
  bpa_cfg_if.sink   cfg_wr
);

  bpa_pkg::cmd_t cmd;
  bpa_pkg::sts_t sts;

  assign cfg_wr.ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpa_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_req.func),
    .in_page_count     (in_req.page_count),
    .in_page           (in_req.page),
    .cfg_valid         (cfg_wr.valid),
    .cfg_data          (cfg_wr.list_capacity),
    .out_ready         (out_rsp.ready),
    .out_valid         (out_rsp.valid),
    .out_status        (out_rsp.status),
    .out_base_page     (out_rsp.base_page),
    .out_granted_order (out_rsp.granted_order),
    .out_evicted       (out_rsp.evicted),
    .out_evicted_page  (out_rsp.evicted_page),
    .out_demoted       (out_rsp.demoted),
    .out_demoted_page  (out_rsp.demoted_page)
  );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0] FN_UNDEF = 2'd3;

  typedef struct {
    logic [1:0]      status;
    bpa_pkg::frame_t base_page;
    bpa_pkg::order_t granted_order;
    logic            evicted;
    bpa_pkg::frame_t evicted_page;
    logic            demoted;
    bpa_pkg::frame_t demoted_page;
  } page_rsp_t;

  class page_frame_board;
    bit         frame_free[bpa_pkg::FRAME_COUNT];
    bit         block_head[bpa_pkg::FRAME_COUNT];
    int         block_order[bpa_pkg::FRAME_COUNT];
    logic [1:0] mark[bpa_pkg::FRAME_COUNT];
    int         inact_q[$];
    int         act_q[$];
    int         capacity;
    page_rsp_t  expected_q[$];
    int         errors;

    function new();
      for (int i = 0; i < bpa_pkg::FRAME_COUNT; i++) begin
        frame_free[i] = 1;
        block_head[i] = (i == 0);
        block_order[i] = (i == 0) ? bpa_pkg::TOP_ORDER : 0;
        mark[i] = bpa_pkg::MK_NONE;
      end
      capacity = bpa_pkg::CAP_RESET;
      errors = 0;
    endfunction

    function void drop_from(ref int q[$], input int pg);
      for (int i = 0; i < q.size(); i++) begin
        if (q[i] == pg) begin
          q.delete(i);
          return;
        end
      end
    endfunction

    function void release_frame(input int pg);
      int o;
      int buddy;
      o = 0;
      if (mark[pg] == bpa_pkg::MK_INACT) drop_from(inact_q, pg);
      else if (mark[pg] == bpa_pkg::MK_ACT) drop_from(act_q, pg);
      mark[pg] = bpa_pkg::MK_NONE;
      frame_free[pg] = 1;
      block_head[pg] = 1;
      block_order[pg] = 0;
      while (o < bpa_pkg::TOP_ORDER) begin
        buddy = pg ^ (1 << o);
        if (buddy >= bpa_pkg::FRAME_COUNT || !block_head[buddy] || block_order[buddy] != o)
          break;
        block_head[pg] = 0;
        block_head[buddy] = 0;
        block_order[pg] = 0;
        block_order[buddy] = 0;
        if (buddy < pg) pg = buddy;
        o++;
        block_head[pg] = 1;
        block_order[pg] = o;
      end
    endfunction

    function void note_request(input logic [1:0] func, input bpa_pkg::count_t cnt,
                               input bpa_pkg::frame_t pg);
      page_rsp_t r;
      int o, m, b, tail;
      r = '{default: '0};
      if (func == bpa_pkg::FN_ALLOC) begin
        o = 0;
        b = -1;
        while (o <= bpa_pkg::TOP_ORDER && (1 << o) < cnt) o++;
        if (cnt > bpa_pkg::FRAME_COUNT || o > bpa_pkg::TOP_ORDER) begin
          r.status = bpa_pkg::ST_NOBLK;
        end else begin
          for (m = o; m <= bpa_pkg::TOP_ORDER && b < 0; m++)
            for (int i = 0; i < bpa_pkg::FRAME_COUNT && b < 0; i++)
              if (block_head[i] && block_order[i] == m) b = i;
          if (b < 0) begin
            r.status = bpa_pkg::ST_NOBLK;
          end else begin
            m = block_order[b];
            block_head[b] = 0;
            block_order[b] = 0;
            while (m > o) begin
              m--;
              block_head[b + (1 << m)] = 1;
              block_order[b + (1 << m)] = m;
            end
            for (int k = 0; k < (1 << o); k++) frame_free[b + k] = 0;
            r.base_page = b;
            r.granted_order = o;
          end
        end
      end else if (func == bpa_pkg::FN_FREE) begin
        if (frame_free[pg]) r.status = bpa_pkg::ST_FREEPG;
        else release_frame(pg);
      end else if (func == bpa_pkg::FN_ACCESS) begin
        if (frame_free[pg]) begin
          r.status = bpa_pkg::ST_FREEPG;
        end else if (mark[pg] == bpa_pkg::MK_NONE) begin
          mark[pg] = bpa_pkg::MK_INACT;
          if (inact_q.size() < bpa_pkg::FRAME_COUNT) inact_q.insert(0, pg);
          if (inact_q.size() > capacity) begin
            tail = inact_q[inact_q.size() - 1];
            inact_q.delete(inact_q.size() - 1);
            mark[tail] = bpa_pkg::MK_NONE;
            release_frame(tail);
            r.evicted = 1;
            r.evicted_page = tail;
          end
        end else if (mark[pg] == bpa_pkg::MK_INACT) begin
          drop_from(inact_q, pg);
          mark[pg] = bpa_pkg::MK_ACT;
          if (act_q.size() < bpa_pkg::FRAME_COUNT) act_q.insert(0, pg);
          if (act_q.size() > capacity) begin
            tail = act_q[act_q.size() - 1];
            act_q.delete(act_q.size() - 1);
            mark[tail] = bpa_pkg::MK_INACT;
            if (inact_q.size() < bpa_pkg::FRAME_COUNT) inact_q.insert(0, tail);
            r.demoted = 1;
            r.demoted_page = tail;
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(input page_rsp_t got);
      page_rsp_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected response, status %0d", got.status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.base_page !== e.base_page) begin
        $error("base_page exp %0d got %0d", e.base_page, got.base_page); errors++;
      end
      if (got.granted_order !== e.granted_order) begin
        $error("granted_order exp %0d got %0d", e.granted_order, got.granted_order); errors++;
      end
      if (got.evicted !== e.evicted) begin
        $error("evicted exp %0d got %0d", e.evicted, got.evicted); errors++;
      end
      if (got.evicted_page !== e.evicted_page) begin
        $error("evicted_page exp %0d got %0d", e.evicted_page, got.evicted_page); errors++;
      end
      if (got.demoted !== e.demoted) begin
        $error("demoted exp %0d got %0d", e.demoted, got.demoted); errors++;
      end
      if (got.demoted_page !== e.demoted_page) begin
        $error("demoted_page exp %0d got %0d", e.demoted_page, got.demoted_page); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bpa_req_if req_if();
  bpa_rsp_if rsp_if();
  bpa_cfg_if cfg_if();

  page_frame_board board;
  bit quiet;
  int hold_cycles;

  buddy_page_allocator_with_two_list_lru_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_rsp(rsp_if),
    .cfg_wr (cfg_if)
  );

  initial clk = 0;
  always #10 clk = ~clk;

  initial begin
    #400_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && req_if.valid && req_if.ready)
      board.note_request(req_if.func, req_if.page_count, req_if.page);
  end

  always @(posedge clk) begin
    page_rsp_t got;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.status = rsp_if.status;
      got.base_page = rsp_if.base_page;
      got.granted_order = rsp_if.granted_order;
      got.evicted = rsp_if.evicted;
      got.evicted_page = rsp_if.evicted_page;
      got.demoted = rsp_if.demoted;
      got.demoted_page = rsp_if.demoted_page;
      board.check_result(got);
    end
  end

  // response side back-pressure
  initial begin
    int n;
    rsp_if.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        rsp_if.ready <= 0;
        hold_cycles--;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        rsp_if.ready <= 1;
      end else begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        rsp_if.ready <= 0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  task automatic send_req(input logic [1:0] func, input bpa_pkg::count_t cnt,
                          input bpa_pkg::frame_t pg);
    @(negedge clk);
    req_if.valid <= 1;
    req_if.func <= func;
    req_if.page_count <= cnt;
    req_if.page <= pg;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic req_gap();
    int n;
    if (quiet || $urandom_range(0, 2) == 0) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    @(negedge clk);
    req_if.valid <= 0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    req_if.valid <= 0;
    while (board.expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_capacity(input bpa_pkg::count_t cap);
    @(negedge clk);
    cfg_if.valid <= 1;
    cfg_if.list_capacity <= cap;
    do @(posedge clk); while (!cfg_if.ready);
    board.capacity = cap;
    @(negedge clk);
    cfg_if.valid <= 0;
  endtask

  function automatic bpa_pkg::frame_t busy_page();
    bpa_pkg::frame_t p;
    for (int t = 0; t < 12; t++) begin
      p = (t < 8) ? bpa_pkg::frame_t'($urandom_range(0, 127))
                  : bpa_pkg::frame_t'($urandom_range(0, 511));
      if (!board.frame_free[p]) return p;
    end
    return p;
  endfunction

  task automatic random_req();
    int r;
    bpa_pkg::count_t cnt;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      r = $urandom_range(0, 19);
      if (r < 16) cnt = bpa_pkg::count_t'($urandom_range(0, 8));
      else if (r < 19) cnt = bpa_pkg::count_t'($urandom_range(9, 64));
      else cnt = bpa_pkg::count_t'($urandom_range(0, 1023));
      send_req(bpa_pkg::FN_ALLOC, cnt, bpa_pkg::frame_t'($urandom_range(0, 511)));
    end else if (r < 52) begin
      send_req(bpa_pkg::FN_FREE, bpa_pkg::count_t'($urandom_range(0, 1023)),
               ($urandom_range(0, 9) == 0) ? bpa_pkg::frame_t'($urandom_range(0, 511))
                                           : busy_page());
    end else if (r < 96) begin
      send_req(bpa_pkg::FN_ACCESS, bpa_pkg::count_t'($urandom_range(0, 1023)),
               ($urandom_range(0, 9) == 0) ? bpa_pkg::frame_t'($urandom_range(0, 511))
                                           : busy_page());
    end else begin
      send_req(FN_UNDEF, bpa_pkg::count_t'($urandom_range(0, 1023)),
               bpa_pkg::frame_t'($urandom_range(0, 511)));
    end
    req_gap();
  endtask

  initial begin
    bpa_pkg::count_t caps[7];
    caps = '{10'd1, 10'd0, 10'd4, 10'd512, 10'd1023, 10'd16, 10'd2};
    board = new();
    quiet = 0;
    hold_cycles = 0;
    rst_n = 0;
    req_if.valid = 0;
    req_if.func = bpa_pkg::FN_ALLOC;
    req_if.page_count = '0;
    req_if.page = '0;
    cfg_if.valid = 0;
    cfg_if.list_capacity = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed requests
    send_req(bpa_pkg::FN_FREE, 10'd0, 9'd0);
    send_req(bpa_pkg::FN_ACCESS, 10'd0, 9'd511);
    send_req(bpa_pkg::FN_ALLOC, 10'd1023, 9'd0);
    send_req(bpa_pkg::FN_ALLOC, 10'd513, 9'd0);
    send_req(bpa_pkg::FN_ALLOC, 10'd0, 9'd0);
    send_req(bpa_pkg::FN_ALLOC, 10'd3, 9'd0);
    send_req(bpa_pkg::FN_ACCESS, 10'd0, 9'd0);
    send_req(bpa_pkg::FN_ACCESS, 10'd0, 9'd0);
    send_req(bpa_pkg::FN_ACCESS, 10'd0, 9'd0);
    send_req(bpa_pkg::FN_ACCESS, 10'd0, 9'd5);
    send_req(FN_UNDEF, 10'h3ff, 9'h1ff);
    send_req(bpa_pkg::FN_FREE, 10'd0, 9'd0);
    send_req(bpa_pkg::FN_FREE, 10'd0, 9'd0);
    send_req(bpa_pkg::FN_FREE, 10'd0, 9'd4);
    send_req(bpa_pkg::FN_FREE, 10'd0, 9'd5);
    send_req(bpa_pkg::FN_FREE, 10'd0, 9'd6);
    send_req(bpa_pkg::FN_FREE, 10'd0, 9'd7);
    send_req(bpa_pkg::FN_ALLOC, 10'd512, 9'd0);
    send_req(bpa_pkg::FN_ACCESS, 10'd0, 9'd511);
    send_req(bpa_pkg::FN_ALLOC, 10'd1, 9'd0);
    send_req(bpa_pkg::FN_FREE, 10'd0, 9'd511);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_capacity(caps[ph]);
      quiet = (ph == 4);
      for (int i = 0; i < 275; i++) begin
        if (ph == 2 && i == 100) hold_cycles = 3000;
        if (ph == 5 && i == 120) drain();
        random_req();
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
